[design/sbid_pkg.sv]
// Package for the stop-bit integer decoder.
// Holds the beat types, status codes and byte masks; depends on nothing.
`default_nettype none

package sbid_pkg;

    localparam logic [7:0] STOP_MASK = 8'h80;
    localparam logic [7:0] SIGN_MASK = 8'h40;
    localparam logic [7:0] DATA_MASK = 8'h7F;
    localparam logic [7:0] NULL_BYTE = 8'h80;

    // Last byte index (zero based) allowed for narrow and wide kinds.
    localparam logic [3:0] LAST_NARROW = 4'd4;
    localparam logic [3:0] LAST_WIDE   = 4'd9;

    // Leading byte top bits that a negative value must carry.
    localparam logic [2:0] NEG_TOP_NARROW = 3'h7;
    localparam logic [5:0] NEG_TOP_WIDE   = 6'h3F;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_NO_STOP  = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;

    // Kind encoding: bit 0 is signed, bit 1 is 64-bit.
    localparam int KIND_SIGNED_BIT = 0;
    localparam int KIND_WIDE_BIT   = 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
        logic [1:0] action;
        logic       nullable;
    } t_in;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } t_out;

    // One classified value handed from the front to the back.
    typedef struct packed {
        logic [63:0] acc;
        logic [1:0]  kind;
        logic        nullable;
        logic [2:0]  status;
    } t_work;

endpackage

`default_nettype wire

[design/sbid_queue.sv]
// Small first-in first-out queue of any packed item type.
// Used between front and back and as the result buffer; no package needed.
`default_nettype none

module sbid_queue #(
    parameter type t_item = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_full,
    input  wire   i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/sbid_front.sv]
// Front end of the decoder: assembles stop-bit bytes and classifies each value.
// Depends on sbid_pkg for the beat types, masks and status codes.
`default_nettype none

module sbid_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_accept,
    input  sbid_pkg::t_in  i_item,
    output logic           o_push,
    output sbid_pkg::t_work o_work
);
    import sbid_pkg::*;

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_lead;
    logic [1:0]  r_kind;
    logic        r_nullable;

    logic        first;
    logic [1:0]  kind;
    logic        nul;
    logic [7:0]  lead;
    logic [7:0]  data;
    logic [3:0]  last;
    logic [63:0] base;
    logic [63:0] acc_new;
    logic [6:0]  lead_bits;
    logic        neg;
    logic        overflow;
    logic        emit;
    logic [2:0]  status;

    assign data      = i_item.data_byte;
    assign first     = (r_count == '0);
    assign kind      = first ? i_item.action : r_kind;
    assign nul       = first ? i_item.nullable : r_nullable;
    assign lead      = first ? data : r_lead;
    assign last      = kind[KIND_WIDE_BIT] ? LAST_WIDE : LAST_NARROW;
    assign base      = first ? {64{kind[KIND_SIGNED_BIT] && ((data & SIGN_MASK) != '0)}}
                             : r_acc;
    assign acc_new   = {base[56:0], data[6:0] & DATA_MASK[6:0]};
    assign lead_bits = lead[6:0];
    assign neg       = kind[KIND_SIGNED_BIT] && ((lead & SIGN_MASK) != '0);

    always_comb begin
        if (kind[KIND_WIDE_BIT]) begin
            overflow = lead_bits[6:1] != (neg ? NEG_TOP_WIDE : 6'h00);
        end else begin
            overflow = lead_bits[6:4] != (neg ? NEG_TOP_NARROW : 3'h0);
        end
    end

    // Priority follows the decode order: end of buffer, null, overflow on the
    // last allowed byte, a stop bit, and finally a missing stop bit.
    always_comb begin
        emit   = 1'b1;
        status = ST_OK;
        if (i_item.buffer_end) begin
            status = ST_END;
        end else if (first && nul && (data == NULL_BYTE)) begin
            status = ST_NULL;
        end else if ((r_count >= last) && overflow) begin
            status = ST_OVERFLOW;
        end else if ((data & STOP_MASK) != '0) begin
            status = ST_OK;
        end else if (r_count >= last) begin
            status = ST_NO_STOP;
        end else begin
            emit = 1'b0;
        end
    end

    assign o_push          = i_accept && emit;
    assign o_work.acc      = acc_new;
    assign o_work.kind     = kind;
    assign o_work.nullable = nul;
    assign o_work.status   = status;

    always_comb begin
        n_count = r_count;
        n_acc   = r_acc;
        if (i_accept) begin
            if (emit) begin
                n_count = '0;
                n_acc   = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_acc   = acc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_acc      <= '0;
            r_lead     <= '0;
            r_kind     <= '0;
            r_nullable <= 1'b0;
        end else begin
            r_count <= n_count;
            r_acc   <= n_acc;
            if (i_accept && first && !i_item.buffer_end) begin
                r_lead     <= data;
                r_kind     <= i_item.action;
                r_nullable <= i_item.nullable;
            end
        end
    end

endmodule

`default_nettype wire

[design/sbid_back.sv]
// Back end of the decoder: sizes, sign-extends and adjusts finished values.
// Depends on sbid_pkg and sbid_queue, which buffers the results.
`default_nettype none

module sbid_back #(
    parameter int OUT_DEPTH = 2
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_work_valid,
    input  sbid_pkg::t_work i_work,
    output logic            o_work_pop,
    input  wire             i_pop,
    output sbid_pkg::t_out  o_result,
    output logic            o_empty
);
    import sbid_pkg::*;

    logic [63:0] sized;
    logic [63:0] dec;
    logic [63:0] final_value;
    logic        is_signed;
    logic        is_wide;
    logic        out_full;
    t_out        result;

    assign is_signed = i_work.kind[KIND_SIGNED_BIT];
    assign is_wide   = i_work.kind[KIND_WIDE_BIT];

    always_comb begin
        if (is_wide) begin
            sized = i_work.acc;
        end else if (is_signed) begin
            sized = {{32{i_work.acc[31]}}, i_work.acc[31:0]};
        end else begin
            sized = {32'h0, i_work.acc[31:0]};
        end
    end

    assign dec = sized - 64'd1;

    // Optional fields shift non-negative values down by one; unsigned ones
    // wrap at the kind's width, signed zero and negatives pass unchanged.
    always_comb begin
        final_value = sized;
        if (i_work.nullable) begin
            if (!is_signed) begin
                final_value = is_wide ? dec : {32'h0, dec[31:0]};
            end else if ((sized != '0) && !sized[63]) begin
                final_value = dec;
            end
        end
        if (i_work.status != ST_OK) begin
            final_value = '0;
        end
    end

    assign result.value  = final_value;
    assign result.status = i_work.status;
    assign o_work_pop    = i_work_valid && !out_full;

    sbid_queue #(
        .t_item (t_out),
        .DEPTH  (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_work_pop),
        .i_item  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_item  (o_result),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

[design/stop_bit_integer_decoder.sv]
// Stop-bit integer decoder, top level.
// Depends on sbid_pkg, sbid_front, sbid_queue and sbid_back.
//
// The decoder takes one stream byte per beat and returns one result beat per
// finished value: a decoded integer with status ok, or a null, overflow,
// missing stop bit or unexpected end report (value zero for all but ok). Each
// byte carries seven data bits, most significant group first, and a set bit 7
// ends the value. The kind (u32, i32, u64, i64) and the nullable flag are
// taken from the first byte's beat and held for the rest of the value. A
// beat with buffer_end set always yields an unexpected end result and drops
// any partial value. Input bytes are accepted at one per clock while the work
// queue is not full, including while results wait on the output side; a
// finished value passes through the work queue between the front and back
// sections, written by the edge that takes its last byte, and then through
// the result queue, written once the result queue has room. The input side
// reports full only when the work queue is full, which happens when the
// result side has stalled long enough to fill both queues.
`default_nettype none

module stop_bit_integer_decoder #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            push,
    output logic           full,
    input  sbid_pkg::t_in  i_item,
    output logic           empty,
    input  wire            pop,
    output sbid_pkg::t_out o_result
);
    import sbid_pkg::*;

    logic  accept;
    logic  front_push;
    t_work front_work;
    t_work mid_work;
    logic  mid_empty;
    logic  mid_pop;

    assign accept = push && !full;

    // Front: byte assembly and classification, one byte per clock while the work queue is not full.
    sbid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (front_push),
        .o_work   (front_work)
    );

    // Work queue that lets the front keep taking bytes while the back stalls.
    sbid_queue #(
        .t_item (t_work),
        .DEPTH  (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_work),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_item  (mid_work),
        .o_empty (mid_empty)
    );

    // Back: value finishing and the result buffer.
    sbid_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!mid_empty),
        .i_work       (mid_work),
        .o_work_pop   (mid_pop),
        .i_pop        (pop),
        .o_result     (o_result),
        .o_empty      (empty)
    );

`ifndef SYNTH
    // Every waiting result carries a defined status code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status == ST_OK || o_result.status == ST_NULL ||
                    o_result.status == ST_OVERFLOW || o_result.status == ST_NO_STOP ||
                    o_result.status == ST_END))
        else $error("result status code out of range");

    // Reports other than ok carry a zero value.
    a_zero_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_OK) |-> (o_result.value == 64'h0))
        else $error("non-ok result with nonzero value");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result waiting after reset");
`endif

endmodule

`default_nettype wire
